>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the radix digit converter.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define RDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/rdc_pkg.sv
// Shared types, constants and the microcode ROM of the radix digit converter.
// No dependencies.
package rdc_pkg;

  localparam int DIGIT_STORE_DEPTH = 32;
  localparam int VALUE_W           = 31;
  localparam int RADIX_W           = 5;
  localparam int DIGIT_W           = 4;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RST = 5'd2;

  // divider: the dividend is walked in chunks of DIV_CHUNK bits per cycle
  localparam int DIV_W      = 32;
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STEPS  = DIV_W / DIV_CHUNK;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_IDLE  = 3'd0;
  localparam pc_t STEP_DIV   = 3'd1;
  localparam pc_t STEP_PUSH  = 3'd2;
  localparam pc_t STEP_POP   = 3'd3;
  localparam pc_t STEP_EMIT  = 3'd4;
  localparam pc_t STEP_DONE  = 3'd5;
  localparam pc_t STEP_EMPTY = 3'd6;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_INPUT = 3'd2,
    COND_IN_ZERO  = 3'd3,
    COND_DIV_MORE = 3'd4,
    COND_QUOT_NZ  = 3'd5,
    COND_OUT_BUSY = 3'd6,
    COND_STACK_NZ = 3'd7
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  load;
    logic  div;
    logic  push;
    logic  pop;
    logic  emit;
    logic  emit_empty;
    cond_t wait_c;   // hold the step while true, actions but in_ready suppressed
    cond_t jmp_c;    // jump to target when true, else fall through
    pc_t   target;
  } ctl_word_t;

  function automatic ctl_word_t ucode_rom(input pc_t pc);
    ctl_word_t cw;
    cw = '{in_ready: 1'b0, load: 1'b0, div: 1'b0, push: 1'b0, pop: 1'b0,
           emit: 1'b0, emit_empty: 1'b0, wait_c: COND_NEVER,
           jmp_c: COND_ALWAYS, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE: begin
        cw.in_ready = 1'b1;
        cw.load     = 1'b1;
        cw.wait_c   = COND_NO_INPUT;
        cw.jmp_c    = COND_IN_ZERO;
        cw.target   = STEP_EMPTY;
      end
      STEP_DIV: begin
        cw.div    = 1'b1;
        cw.jmp_c  = COND_DIV_MORE;
        cw.target = STEP_DIV;
      end
      STEP_PUSH: begin
        cw.push   = 1'b1;
        cw.jmp_c  = COND_QUOT_NZ;
        cw.target = STEP_DIV;
      end
      STEP_POP: begin
        cw.pop   = 1'b1;
        cw.jmp_c = COND_NEVER;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.wait_c = COND_OUT_BUSY;
        cw.jmp_c  = COND_STACK_NZ;
        cw.target = STEP_POP;
      end
      STEP_DONE: begin
        cw.jmp_c  = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
      STEP_EMPTY: begin
        cw.emit_empty = 1'b1;
        cw.wait_c     = COND_OUT_BUSY;
        cw.jmp_c      = COND_ALWAYS;
        cw.target     = STEP_IDLE;
      end
      default: begin
        cw.jmp_c  = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/radix_digit_converter_unit.sv
// Top level of the radix digit converter: microcode sequencer, divider, digit stack.
// Depends on rdc_pkg, rdc_ram and assert_macros.svh.
//
// Usage:
//   in_*  : one 31-bit non-negative value per transfer (in_tdata[30:0]).
//   out_* : one digit per transfer, most significant first; out_tlast marks the
//           final digit. A zero input gives a single transfer with out_tuser
//           (empty flag) and out_tlast set and digit zero.
//   cfg_* : radix write, clamped to 2..16; reset value 2. Write only when idle.
// Timing: each digit costs a pass of the 8-bit-per-cycle restoring divider over
//   the whole dividend plus a push, then a read of the digit stack and a load of
//   the output register; a value has at most 31 digits (radix 2). The first digit
//   appears only after every digit has been pushed. One value is converted at a
//   time; in_tready is high only while the sequencer waits at its idle step.
// Reset: sequencer to idle, stack empty, output register empty, radix 2.
// Stall: the output register holds its digit while out_tready is low and the
//   sequencer waits at its emit or empty step until the register can be reloaded.
`include "assert_macros.svh"

module radix_digit_converter_unit #(
  parameter int DIGIT_STORE_DEPTH = rdc_pkg::DIGIT_STORE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // value[30:0]
  input  logic [rdc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // digit[3:0]
  output logic [rdc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // empty_res[0]
  output logic                              out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [rdc_pkg::RADIX_W-1:0]       cfg_wr_data
);

  localparam int AW   = $clog2(DIGIT_STORE_DEPTH);
  localparam int SP_W = $clog2(DIGIT_STORE_DEPTH + 1);

  rdc_pkg::pc_t      pc_r, pc_nxt;
  rdc_pkg::ctl_word_t cw;
  logic              wait_hit, jump_hit, go;

  logic [rdc_pkg::RADIX_W-1:0]   radix_r;
  logic [rdc_pkg::DIV_W-1:0]     quot_r, quot_nxt;
  logic [rdc_pkg::DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [rdc_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [SP_W-1:0]               sp_r;
  logic [rdc_pkg::DIGIT_W-1:0]   stack_rd_data;
  logic                          stack_we, stack_re;

  logic                          out_valid_r, out_empty_r, out_last_r;
  logic [rdc_pkg::DIGIT_W-1:0]   out_digit_r;
  logic                          out_busy;

  assign out_busy = out_valid_r && !out_tready;

  function automatic logic cond_eval(
    input rdc_pkg::cond_t c,
    input logic in_v, input logic in_z, input logic dmore,
    input logic qnz, input logic obusy, input logic snz
  );
    logic r;
    unique case (c)
      rdc_pkg::COND_NEVER:    r = 1'b0;
      rdc_pkg::COND_ALWAYS:   r = 1'b1;
      rdc_pkg::COND_NO_INPUT: r = !in_v;
      rdc_pkg::COND_IN_ZERO:  r = in_z;
      rdc_pkg::COND_DIV_MORE: r = dmore;
      rdc_pkg::COND_QUOT_NZ:  r = qnz;
      rdc_pkg::COND_OUT_BUSY: r = obusy;
      rdc_pkg::COND_STACK_NZ: r = snz;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  logic in_zero, div_more, quot_nz, stack_nz;
  assign in_zero  = (in_tdata[rdc_pkg::VALUE_W-1:0] == '0);
  assign div_more = (div_cnt_r != rdc_pkg::DIV_CNT_W'(rdc_pkg::DIV_STEPS - 1));
  assign quot_nz  = (quot_r != '0);
  assign stack_nz = (sp_r != '0);

  // sequencer
  always_comb begin
    cw       = rdc_pkg::ucode_rom(pc_r);
    wait_hit = cond_eval(cw.wait_c, in_tvalid, in_zero, div_more, quot_nz,
                         out_busy, stack_nz);
    jump_hit = cond_eval(cw.jmp_c, in_tvalid, in_zero, div_more, quot_nz,
                         out_busy, stack_nz);
    go       = !wait_hit;
    if (wait_hit) begin
      pc_nxt = pc_r;
    end else if (jump_hit) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  assign in_tready = cw.in_ready;

  // one chunk of restoring division by the radix; the remainder stays below 16
  always_comb begin
    logic [rdc_pkg::DIGIT_W-1:0]   rem_v;
    logic [rdc_pkg::DIGIT_W:0]     trial;
    logic [rdc_pkg::DIV_CHUNK-1:0] chunk, qbits;
    rem_v = (div_cnt_r == '0) ? '0 : rem_r;
    chunk = quot_r[rdc_pkg::DIV_W-1 -: rdc_pkg::DIV_CHUNK];
    qbits = '0;
    for (int i = rdc_pkg::DIV_CHUNK - 1; i >= 0; i--) begin
      trial = {rem_v, chunk[i]};
      if (trial >= radix_r) begin
        rem_v    = rdc_pkg::DIGIT_W'(trial - radix_r);
        qbits[i] = 1'b1;
      end else begin
        rem_v = trial[rdc_pkg::DIGIT_W-1:0];
      end
    end
    rem_nxt  = rem_v;
    quot_nxt = {quot_r[rdc_pkg::DIV_W-rdc_pkg::DIV_CHUNK-1:0], qbits};
  end

  assign stack_we = go && cw.push && (sp_r < SP_W'(DIGIT_STORE_DEPTH));
  assign stack_re = go && cw.pop;

  rdc_ram #(
    .WIDTH (rdc_pkg::DIGIT_W),
    .DEPTH (DIGIT_STORE_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stack_we),
    .wr_addr (sp_r[AW-1:0]),
    .wr_data (rem_r),
    .rd_en   (stack_re),
    .rd_addr (AW'(sp_r - 1'b1)),
    .rd_data (stack_rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= rdc_pkg::STEP_IDLE;
      radix_r     <= rdc_pkg::RADIX_RST;
      div_cnt_r   <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr_en) begin
        if (cfg_wr_data < rdc_pkg::RADIX_MIN) begin
          radix_r <= rdc_pkg::RADIX_MIN;
        end else if (cfg_wr_data > rdc_pkg::RADIX_MAX) begin
          radix_r <= rdc_pkg::RADIX_MAX;
        end else begin
          radix_r <= cfg_wr_data;
        end
      end
      if (go && cw.load) begin
        div_cnt_r <= '0;
      end else if (go && cw.div) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      if (stack_we) begin
        sp_r <= sp_r + 1'b1;
      end else if (stack_re) begin
        sp_r <= sp_r - 1'b1;
      end
      if (go && (cw.emit || cw.emit_empty)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (go && cw.load) begin
      quot_r <= {{(rdc_pkg::DIV_W - rdc_pkg::VALUE_W){1'b0}},
                 in_tdata[rdc_pkg::VALUE_W-1:0]};
    end else if (go && cw.div) begin
      quot_r <= quot_nxt;
    end
    if (go && cw.div) begin
      rem_r <= rem_nxt;
    end
    if (go && cw.emit) begin
      out_digit_r <= stack_rd_data;
      out_empty_r <= 1'b0;
      out_last_r  <= (sp_r == '0);
    end else if (go && cw.emit_empty) begin
      out_digit_r <= '0;
      out_empty_r <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tdata  = {{(rdc_pkg::OUT_DATA_W - rdc_pkg::DIGIT_W){1'b0}}, out_digit_r};
  assign out_tuser  = out_empty_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  `RDC_ASSERT(a_sp_in_range, clk, rst_n, sp_r <= SP_W'(DIGIT_STORE_DEPTH),
              "digit stack pointer beyond depth")
  `RDC_ASSERT(a_start_empty, clk, rst_n, (in_tvalid && in_tready) |-> (sp_r == '0),
              "conversion started with a non-empty stack")
  `RDC_ASSERT(a_no_overwrite, clk, rst_n, (go && (cw.emit || cw.emit_empty)) |-> !out_busy,
              "output register reloaded while stalled")
  `RDC_ASSERT(a_empty_is_last, clk, rst_n,
              (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == '0),
              "empty result not marked last")

endmodule
